FILE: src/fonidx_pkg.sv
// constants, types and bit-interleave helpers for the octree neighbor index block
// standalone package, no dependencies
package fonidx_pkg;

   localparam int MAX_DEPTH  = 8;
   localparam int BATCH_BITS = 8;

   localparam int DEPTH_W   = 4;
   localparam int BATCH_W   = 8;
   localparam int BLOCK_W   = 21;
   localparam int OFFSET_W  = 2;
   localparam int INDEX_W   = 32;
   localparam int COORD_W   = MAX_DEPTH;
   localparam int SUM_W     = COORD_W + 1;
   localparam int SHIFT_W   = $clog2(3 * MAX_DEPTH + 1);

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(4);
   localparam logic [DEPTH_W-1:0] DEPTH_MIN   = DEPTH_W'(1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX   = DEPTH_W'(MAX_DEPTH);

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [INDEX_W-1:0] index_type;

   // child zero has its three low code bits clear, so coordinate bit k comes
   // from block bit 3*(k-1)+pos
   function automatic coord_type gather_axis(input logic [BLOCK_W-1:0] block,
                                             input logic [DEPTH_W-1:0] depth,
                                             input int pos);
      coord_type v;
      int src;
      v = '0;
      for (int k = 1; k < COORD_W; k++) begin
         src = 3 * (k - 1) + pos;
         if (k < int'(depth) && src < BLOCK_W) begin
            v[k] = block[src];
         end
      end
      return v;
   endfunction

   function automatic index_type spread_axis(input coord_type v, input int pos);
      index_type code;
      code = '0;
      for (int k = 0; k < COORD_W; k++) begin
         if (3 * k + pos < INDEX_W) begin
            code[3 * k + pos] = v[k];
         end
      end
      return code;
   endfunction

endpackage

FILE: src/full_octree_neighbor_index.sv
// top level of the full octree neighbor index block
// depends on fonidx_pkg
//
// Maps a sibling block and a per-axis offset (value minus one) to the Morton
// index of the neighboring node in a full octree of depth 1..MAX_DEPTH, plus
// batch * 8^depth; a neighbor outside the grid gives neighbor_valid low and a
// zero index. One item per cycle unless rsp_stall holds the output. Path: an
// input register, one pass of de-interleave, add, bound check and
// re-interleave, and a result register. The depth register clamps written
// values to 1..MAX_DEPTH and must only be written while the block is empty.
module full_octree_neighbor_index
   import fonidx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BATCH_W-1:0] req_batch_index,
   input  logic [BLOCK_W-1:0] req_block_index,
   input  logic [OFFSET_W-1:0] req_offset_x,
   input  logic [OFFSET_W-1:0] req_offset_y,
   input  logic [OFFSET_W-1:0] req_offset_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_neighbor_valid,
   output logic [INDEX_W-1:0] rsp_neighbor_index,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [DEPTH_W-1:0] csr_tree_depth
);

   logic [DEPTH_W-1:0]  tree_depth_ff, tree_depth_in;

   logic                s1_valid_ff;
   logic [BATCH_W-1:0]  s1_batch_ff;
   logic [BLOCK_W-1:0]  s1_block_ff;
   logic [OFFSET_W-1:0] s1_off_x_ff, s1_off_y_ff, s1_off_z_ff;

   logic                rsp_valid_ff;
   logic                rsp_nvalid_ff, rsp_nvalid_in;
   index_type           rsp_index_ff, rsp_index_in;

   logic                out_advance;
   logic                s1_load;

   coord_type           coord_x, coord_y, coord_z;
   logic [SUM_W-1:0]    sum_x, sum_y, sum_z;
   logic [SUM_W-1:0]    c_x, c_y, c_z;
   logic                in_x, in_y, in_z;
   logic [SHIFT_W-1:0]  batch_shift;
   index_type           key;

   assign csr_ready   = 1'b1;
   assign out_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !out_advance;
   assign s1_load     = req_valid && !req_stall;

   always_comb begin
      tree_depth_in = csr_tree_depth;
      if (csr_tree_depth < DEPTH_MIN) begin
         tree_depth_in = DEPTH_MIN;
      end else if (csr_tree_depth > DEPTH_MAX) begin
         tree_depth_in = DEPTH_MAX;
      end
   end

   always_comb begin
      coord_x = gather_axis(s1_block_ff, tree_depth_ff, 2);
      coord_y = gather_axis(s1_block_ff, tree_depth_ff, 1);
      coord_z = gather_axis(s1_block_ff, tree_depth_ff, 0);

      sum_x = SUM_W'(coord_x) + SUM_W'(s1_off_x_ff);
      sum_y = SUM_W'(coord_y) + SUM_W'(s1_off_y_ff);
      sum_z = SUM_W'(coord_z) + SUM_W'(s1_off_z_ff);

      c_x = sum_x - SUM_W'(1);
      c_y = sum_y - SUM_W'(1);
      c_z = sum_z - SUM_W'(1);

      // below zero or at 2^depth and above lies outside
      in_x = (sum_x != '0) && ((c_x >> tree_depth_ff) == '0);
      in_y = (sum_y != '0) && ((c_y >> tree_depth_ff) == '0);
      in_z = (sum_z != '0) && ((c_z >> tree_depth_ff) == '0);

      batch_shift = SHIFT_W'(tree_depth_ff) + SHIFT_W'(tree_depth_ff)
                  + SHIFT_W'(tree_depth_ff);

      key = spread_axis(c_x[COORD_W-1:0], 2)
          | spread_axis(c_y[COORD_W-1:0], 1)
          | spread_axis(c_z[COORD_W-1:0], 0);

      rsp_nvalid_in = in_x && in_y && in_z;
      rsp_index_in  = '0;
      if (rsp_nvalid_in) begin
         rsp_index_in = key + (INDEX_W'(s1_batch_ff[BATCH_BITS-1:0]) << batch_shift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_depth_ff <= DEPTH_RESET;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            tree_depth_ff <= tree_depth_in;
         end
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (out_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_batch_ff <= req_batch_index;
         s1_block_ff <= req_block_index;
         s1_off_x_ff <= req_offset_x;
         s1_off_y_ff <= req_offset_y;
         s1_off_z_ff <= req_offset_z;
      end
      if (out_advance && s1_valid_ff) begin
         rsp_nvalid_ff <= rsp_nvalid_in;
         rsp_index_ff  <= rsp_index_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neighbor_valid = rsp_nvalid_ff;
   assign rsp_neighbor_index = rsp_index_ff;

`ifndef SYNTH
   a_no_neighbor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_neighbor_valid |-> rsp_neighbor_index == '0)
      else $error("no-neighbor result carries a nonzero index");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      tree_depth_ff >= DEPTH_MIN && tree_depth_ff <= DEPTH_MAX)
      else $error("depth register out of range");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while both stages are held");

   a_transfer_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted transfer lost in input stage");
`endif

endmodule
